FILE: rtl/synthetic_fluoro_pattern_generator_core_defines.svh
// Assertion macros shared by the pattern generator RTL.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef SYNTHETIC_FLUORO_PATTERN_GENERATOR_CORE_DEFINES_SVH
`define SYNTHETIC_FLUORO_PATTERN_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define SFPG_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define SFPG_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/sfpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfpg_pkg;

   // Parameter defaults
   localparam int PHASE_STEPS_DEFAULT    = 60;
   localparam int COORD_BITS_DEFAULT     = 12;
   localparam int SINE_FRAC_BITS_DEFAULT = 15;

   // Port field widths
   localparam int PIXEL_X_W    = 12;
   localparam int PIXEL_Y_W    = 12;
   localparam int GREY_W       = 16;
   localparam int MARKER_X_W   = 12;
   localparam int MARKER_Y_W   = 13;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   // Configuration register widths
   localparam int MODE_W       = 3;
   localparam int SIZE_W       = 13;
   localparam int AMP_W        = 12;
   localparam int AMP_FRAC_BITS = 8;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_AMPLITUDE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_GREY     = 3'd4;

   // Pattern modes
   localparam logic [MODE_W-1:0] MODE_RAMP   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CLIP   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SINGLE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ALT    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LINE   = 3'd4;

   // Configuration reset values
   localparam logic [MODE_W-1:0] RESET_MODE      = MODE_CLIP;
   localparam logic [SIZE_W-1:0] RESET_WIDTH     = 13'd2048;
   localparam logic [SIZE_W-1:0] RESET_HEIGHT    = 13'd1536;
   localparam logic [AMP_W-1:0]  RESET_AMPLITUDE = 12'd256;
   localparam logic [GREY_W-1:0] RESET_MAX_GREY  = 16'd16383;

   // Pulse countdowns
   localparam int SD_W = 5;
   localparam int SB_W = 5;
   localparam int AD_W = 4;
   localparam int AB_W = 4;
   localparam logic [SD_W-1:0] SINGLE_DARK_RELOAD   = 5'd10;
   localparam logic [SB_W-1:0] SINGLE_BRIGHT_RELOAD = 5'd20;
   localparam logic [AD_W-1:0] ALT_DARK_RELOAD      = 4'd10;
   localparam logic [AB_W-1:0] ALT_BRIGHT_RELOAD    = 4'd10;

   // Grey levels
   localparam logic [GREY_W-1:0] CLIP_BG        = 16'd800;
   localparam logic [GREY_W-1:0] CLIP_FG        = 16'd200;
   localparam logic [GREY_W-1:0] LINE_LEVEL     = 16'd400;
   localparam logic [GREY_W-1:0] BRIGHT_BG      = 16'd300;
   localparam logic [GREY_W-1:0] BRIGHT_FG      = 16'd100;
   localparam logic [GREY_W-1:0] SINGLE_DARK_BG = 16'd30;
   localparam logic [GREY_W-1:0] ALT_DARK_BG    = 16'd20;
   localparam logic [GREY_W-1:0] DARK_FG        = 16'd10;

   // Geometry
   localparam int RAMP_BAND_ROWS = 50;
   localparam int MOTION_ROWS    = 50;
   localparam int MARK_HALF_W    = 3;
   localparam int MARK_HALF_H    = 5;
   localparam int MARKER_Y_MAX   = 4095;
   localparam int MARKER_Y_MIN   = -4096;

   // pi/2 in Q30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Ramp divider
   localparam int DIV_CNT_W = $clog2(GREY_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINE,
      ST_SCALE,
      ST_PLACE,
      ST_PIXEL,
      ST_DIVIDE,
      ST_RESULT
   } sfpg_state_type;

   typedef struct packed {
      logic load_item;
      logic sine_read;
      logic scale;
      logic place;
      logic product;
      logic div_step;
      logic emit;
      logic emit_quot;
   } sfpg_cmd_type;

   typedef struct packed {
      logic in_update;
      logic need_divide;
      logic div_last;
      logic out_free;
   } sfpg_status_type;

endpackage

`default_nettype wire

FILE: rtl/sfpg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "synthetic_fluoro_pattern_generator_core_defines.svh"

module sfpg_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire sfpg_pkg::sfpg_status_type status,
   output sfpg_pkg::sfpg_cmd_type         cmd
);

   sfpg_pkg::sfpg_state_type state_ff;
   sfpg_pkg::sfpg_state_type state_in;
   sfpg_pkg::sfpg_state_type item_state;

   // where a freshly accepted transaction starts
   assign item_state = status.in_update ? sfpg_pkg::ST_SINE : sfpg_pkg::ST_PIXEL;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfpg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfpg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = item_state;
            end
         end
         sfpg_pkg::ST_SINE:  state_in = sfpg_pkg::ST_SCALE;
         sfpg_pkg::ST_SCALE: state_in = sfpg_pkg::ST_PLACE;
         sfpg_pkg::ST_PLACE: state_in = sfpg_pkg::ST_PIXEL;
         sfpg_pkg::ST_PIXEL: begin
            if (status.need_divide) begin
               state_in = sfpg_pkg::ST_DIVIDE;
            end else if (status.out_free) begin
               state_in = req_valid ? item_state : sfpg_pkg::ST_IDLE;
            end
         end
         sfpg_pkg::ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = sfpg_pkg::ST_RESULT;
            end
         end
         sfpg_pkg::ST_RESULT: begin
            if (status.out_free) begin
               state_in = req_valid ? item_state : sfpg_pkg::ST_IDLE;
            end
         end
         default: state_in = sfpg_pkg::ST_IDLE;
      endcase
   end

   // commands and input stall
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         sfpg_pkg::ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.load_item = req_valid;
         end
         sfpg_pkg::ST_SINE:  cmd.sine_read = 1'b1;
         sfpg_pkg::ST_SCALE: cmd.scale     = 1'b1;
         sfpg_pkg::ST_PLACE: cmd.place     = 1'b1;
         sfpg_pkg::ST_PIXEL: begin
            if (status.need_divide) begin
               cmd.product = 1'b1;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               req_stall     = 1'b0;
               cmd.load_item = req_valid;
            end
         end
         sfpg_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         sfpg_pkg::ST_RESULT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_quot = 1'b1;
               req_stall     = 1'b0;
               cmd.load_item = req_valid;
            end
         end
         default: ;
      endcase
   end

   `SFPG_ASSERT_NEXT(a_divide_exit, state_ff == sfpg_pkg::ST_DIVIDE && status.div_last, state_ff == sfpg_pkg::ST_RESULT, "divider did not hand over to result")
   `SFPG_ASSERT_IMPLIES(a_emit_free, cmd.emit, status.out_free, "result register overwritten")

endmodule

`default_nettype wire

FILE: rtl/sfpg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "synthetic_fluoro_pattern_generator_core_defines.svh"

module sfpg_datapath #(
   parameter int PHASE_STEPS    = sfpg_pkg::PHASE_STEPS_DEFAULT,
   parameter int COORD_BITS     = sfpg_pkg::COORD_BITS_DEFAULT,
   parameter int SINE_FRAC_BITS = sfpg_pkg::SINE_FRAC_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [sfpg_pkg::PIXEL_X_W-1:0]      req_pixel_x,
   input  wire logic [sfpg_pkg::PIXEL_Y_W-1:0]      req_pixel_y,
   input  wire logic                                req_frame_start,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output logic [sfpg_pkg::GREY_W-1:0]              rsp_pixel_value,
   output logic [sfpg_pkg::MARKER_X_W-1:0]          rsp_marker_x,
   output logic signed [sfpg_pkg::MARKER_Y_W-1:0]   rsp_marker_y,
   input  wire logic                                csr_write_enable,
   input  wire logic [sfpg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sfpg_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  wire sfpg_pkg::sfpg_cmd_type              cmd,
   output sfpg_pkg::sfpg_status_type                status
);

   localparam int CW     = COORD_BITS;
   localparam int SZW    = COORD_BITS + 1;
   localparam int SW     = COORD_BITS + 3;
   localparam int DW     = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
   localparam int YW     = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
   localparam int PW     = $clog2(PHASE_STEPS);
   localparam int MAGW   = SINE_FRAC_BITS + 1;
   localparam int AMPW   = sfpg_pkg::AMP_W;
   localparam int A50W   = AMPW + 6;
   localparam int SCW    = A50W + MAGW;
   localparam int OFFSH  = sfpg_pkg::AMP_FRAC_BITS + SINE_FRAC_BITS;
   localparam int OFFW   = SCW - OFFSH;
   localparam int GW     = sfpg_pkg::GREY_W;
   localparam int PRW    = GW + COORD_BITS;
   localparam int MW     = sfpg_pkg::MODE_W;
   localparam int ZW     = sfpg_pkg::SIZE_W;
   localparam int MXW    = sfpg_pkg::MARKER_X_W;
   localparam int MYW    = sfpg_pkg::MARKER_Y_W;
   localparam int SDW    = sfpg_pkg::SD_W;
   localparam int SBW    = sfpg_pkg::SB_W;
   localparam int ADW    = sfpg_pkg::AD_W;
   localparam int ABW    = sfpg_pkg::AB_W;
   localparam int CNTW   = sfpg_pkg::DIV_CNT_W;
   localparam int unsigned SIZE_TOP = 1 << COORD_BITS;
   localparam longint unsigned STEPS_L = 64'(PHASE_STEPS);

   localparam logic signed [YW-1:0] Y_MAX  = YW'(sfpg_pkg::MARKER_Y_MAX);
   localparam logic signed [YW-1:0] Y_MIN  = YW'(sfpg_pkg::MARKER_Y_MIN);
   localparam logic signed [SW-1:0] BAND_S = SW'(sfpg_pkg::RAMP_BAND_ROWS);
   localparam logic signed [SW-1:0] ONE_S  = SW'(1);
   localparam logic signed [SW-1:0] HW_S   = SW'(sfpg_pkg::MARK_HALF_W);
   localparam logic signed [DW-1:0] HH_S   = DW'(sfpg_pkg::MARK_HALF_H);

   // sin(2*pi*k/PHASE_STEPS): {negative, magnitude in Q(SINE_FRAC_BITS)}
   function automatic logic [MAGW:0] sine_entry(input int unsigned k);
      longint unsigned u;
      longint unsigned q;
      longint unsigned r;
      longint unsigned g;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned val;
      longint          sum;
      u    = 64'(k) << 2;
      q    = u / STEPS_L;
      r    = u % STEPS_L;
      g    = q[0] ? (STEPS_L - r) : r;
      x    = (sfpg_pkg::HALF_PI_Q30 * g) / STEPS_L;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - signed'(term);
      if (sum < 0) begin
         sum = 0;
      end
      val = (unsigned'(sum) + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
      if (val > (64'd1 << SINE_FRAC_BITS)) begin
         val = 64'd1 << SINE_FRAC_BITS;
      end
      return {(q >= 64'd2), MAGW'(val)};
   endfunction

   logic [MAGW:0] sine_rom [PHASE_STEPS];

   for (genvar k = 0; k < PHASE_STEPS; k++) begin : g_sine
      localparam logic [MAGW:0] ENTRY = sine_entry(k);
      assign sine_rom[k] = ENTRY;
   end

   // configuration
   logic [MW-1:0]   mode_ff,   mode_in;
   logic [ZW-1:0]   width_ff,  width_in;
   logic [ZW-1:0]   height_ff, height_in;
   logic [AMPW-1:0] amp_ff,    amp_in;
   logic [GW-1:0]   grey_ff,   grey_in;

   // frame state
   logic [PW-1:0]          phase_ff,  phase_in;
   logic [SDW-1:0]         sd_ff,     sd_in;
   logic [SBW-1:0]         sb_ff,     sb_in;
   logic [ADW-1:0]         ad_ff,     ad_in;
   logic [ABW-1:0]         ab_ff,     ab_in;
   logic                   bright_ff, bright_in;
   logic [CW-1:0]          mx_ff,     mx_in;
   logic signed [MYW-1:0]  my_ff,     my_in;

   // item and arithmetic
   logic [CW-1:0]    x_ff,       x_in;
   logic [CW-1:0]    y_ff,       y_in;
   logic [MAGW-1:0]  sin_mag_ff, sin_mag_in;
   logic             sin_neg_ff, sin_neg_in;
   logic [A50W-1:0]  amp50_ff,   amp50_in;
   logic [SCW-1:0]   scale_ff,   scale_in;
   logic [CW-1:0]    rem_ff,     rem_in;
   logic [GW-1:0]    quot_ff,    quot_in;
   logic [CNTW-1:0]  cnt_ff,     cnt_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GW-1:0]          rsp_value_ff, rsp_value_in;
   logic [MXW-1:0]         rsp_mx_ff,    rsp_mx_in;
   logic signed [MYW-1:0]  rsp_my_ff,    rsp_my_in;

   logic [MW-1:0]          mode_eff;
   logic [SZW-1:0]         w_eff;
   logic [SZW-1:0]         h_eff;
   logic [CW-1:0]          w_half;
   logic [CW-1:0]          h_half;
   logic [MAGW:0]          sine_word;
   logic [OFFW-1:0]        offset;
   logic signed [YW-1:0]   y_sum;
   logic signed [YW-1:0]   y_sat;
   logic signed [SW-1:0]   xs;
   logic signed [SW-1:0]   ys;
   logic signed [SW-1:0]   ws;
   logic signed [SW-1:0]   hs;
   logic signed [SW-1:0]   dx;
   logic signed [DW-1:0]   dy;
   logic                   in_frame;
   logic                   band;
   logic                   diag;
   logic                   marker_hit;
   logic [GW-1:0]          bg;
   logic [GW-1:0]          fg;
   logic [GW-1:0]          pix_value;
   logic [PRW-1:0]         product;
   logic [CW:0]            trial;
   logic                   ramp_mode;

   // effective configuration
   always_comb begin
      mode_eff = (mode_ff > sfpg_pkg::MODE_LINE) ? sfpg_pkg::MODE_CLIP : mode_ff;
      if (width_ff == '0) begin
         w_eff = SZW'(1);
      end else if (32'(width_ff) > SIZE_TOP) begin
         w_eff = SZW'(SIZE_TOP);
      end else begin
         w_eff = SZW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = SZW'(1);
      end else if (32'(height_ff) > SIZE_TOP) begin
         h_eff = SZW'(SIZE_TOP);
      end else begin
         h_eff = SZW'(height_ff);
      end
      w_half = CW'(w_eff >> 1);
      h_half = CW'(h_eff >> 1);
   end

   assign ramp_mode = (mode_eff == sfpg_pkg::MODE_RAMP);

   // configuration writes
   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      amp_in    = amp_ff;
      grey_in   = grey_ff;
      if (csr_write_enable) begin
         case (csr_index)
            sfpg_pkg::REG_PATTERN_MODE: mode_in   = csr_write_data[MW-1:0];
            sfpg_pkg::REG_FRAME_WIDTH:  width_in  = csr_write_data[ZW-1:0];
            sfpg_pkg::REG_FRAME_HEIGHT: height_in = csr_write_data[ZW-1:0];
            sfpg_pkg::REG_AMPLITUDE:    amp_in    = csr_write_data[AMPW-1:0];
            sfpg_pkg::REG_MAX_GREY:     grey_in   = csr_write_data[GW-1:0];
            default: ;
         endcase
      end
   end

   // marker placement: sine read, scale, then offset and saturate
   assign sine_word = sine_rom[phase_ff];
   assign offset    = scale_ff[SCW-1:OFFSH];

   always_comb begin
      if (sin_neg_ff) begin
         y_sum = $signed(YW'(h_half)) - $signed(YW'(offset));
      end else begin
         y_sum = $signed(YW'(h_half)) + $signed(YW'(offset));
      end
      if (y_sum > Y_MAX) begin
         y_sat = Y_MAX;
      end else if (y_sum < Y_MIN) begin
         y_sat = Y_MIN;
      end else begin
         y_sat = y_sum;
      end
   end

   always_comb begin
      sin_mag_in = cmd.sine_read ? sine_word[MAGW-1:0] : sin_mag_ff;
      sin_neg_in = cmd.sine_read ? sine_word[MAGW] : sin_neg_ff;
      amp50_in   = cmd.sine_read ? A50W'(amp_ff) * A50W'(sfpg_pkg::MOTION_ROWS) : amp50_ff;
      scale_in   = cmd.scale ? SCW'(amp50_ff) * SCW'(sin_mag_ff) : scale_ff;
   end

   // frame state update
   always_comb begin
      phase_in  = phase_ff;
      sd_in     = sd_ff;
      sb_in     = sb_ff;
      ad_in     = ad_ff;
      ab_in     = ab_ff;
      bright_in = bright_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      if (cmd.place) begin
         mx_in    = w_half;
         my_in    = MYW'(y_sat);
         phase_in = (phase_ff == PW'(PHASE_STEPS - 1)) ? '0 : phase_ff + PW'(1);
         case (mode_eff)
            sfpg_pkg::MODE_SINGLE: begin
               if (sd_ff != '0 || sb_ff == '0) begin
                  if (sd_ff != '0) begin
                     sd_in = sd_ff - SDW'(1);
                  end
                  bright_in = 1'b0;
               end else begin
                  sb_in     = sb_ff - SBW'(1);
                  bright_in = 1'b1;
               end
            end
            sfpg_pkg::MODE_ALT: begin
               if (ad_ff != '0) begin
                  ad_in = ad_ff - ADW'(1);
                  if (ad_ff == ADW'(1)) begin
                     ab_in = sfpg_pkg::ALT_BRIGHT_RELOAD;
                  end
                  bright_in = 1'b0;
               end else begin
                  ab_in = ab_ff - ABW'(1);
                  if (ab_ff == ABW'(1)) begin
                     ad_in = sfpg_pkg::ALT_DARK_RELOAD;
                  end
                  bright_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // pixel classification
   always_comb begin
      xs       = $signed(SW'(x_ff));
      ys       = $signed(SW'(y_ff));
      ws       = $signed(SW'(w_eff));
      hs       = $signed(SW'(h_eff));
      in_frame = (SZW'(x_ff) < w_eff) && (SZW'(y_ff) < h_eff);
      band     = (ys < BAND_S) || (ys > hs - BAND_S);
      diag     = (xs == ys) || (xs == ys + (ws - hs)) ||
                 (xs == ws - ONE_S - ys) || (xs == hs - ONE_S - ys);
      dx       = xs - $signed(SW'(mx_ff));
      dy       = $signed(DW'(y_ff)) - DW'(my_ff);
      marker_hit = (dx >= -HW_S) && (dx <= HW_S) && (dy >= -HH_S) && (dy <= HH_S);
   end

   always_comb begin
      case (mode_eff)
         sfpg_pkg::MODE_SINGLE: begin
            bg = bright_ff ? sfpg_pkg::BRIGHT_BG : sfpg_pkg::SINGLE_DARK_BG;
            fg = bright_ff ? sfpg_pkg::BRIGHT_FG : sfpg_pkg::DARK_FG;
         end
         sfpg_pkg::MODE_ALT: begin
            bg = bright_ff ? sfpg_pkg::BRIGHT_BG : sfpg_pkg::ALT_DARK_BG;
            fg = bright_ff ? sfpg_pkg::BRIGHT_FG : sfpg_pkg::DARK_FG;
         end
         default: begin
            bg = sfpg_pkg::CLIP_BG;
            fg = sfpg_pkg::CLIP_FG;
         end
      endcase
   end

   always_comb begin
      if (!in_frame) begin
         pix_value = '0;
      end else if (ramp_mode) begin
         pix_value = grey_ff;
      end else if (marker_hit) begin
         pix_value = fg;
      end else if (mode_eff == sfpg_pkg::MODE_LINE && diag) begin
         pix_value = sfpg_pkg::LINE_LEVEL;
      end else begin
         pix_value = bg;
      end
   end

   // ramp divider: max_grey*x / w, one quotient bit a cycle
   assign product = PRW'(grey_ff) * PRW'(x_ff);
   assign trial   = {rem_ff, quot_ff[GW-1]};

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (cmd.product) begin
         rem_in  = product[PRW-1:GW];
         quot_in = product[GW-1:0];
         cnt_in  = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + CNTW'(1);
         if (trial >= w_eff) begin
            rem_in  = CW'(trial - w_eff);
            quot_in = {quot_ff[GW-2:0], 1'b1};
         end else begin
            rem_in  = CW'(trial);
            quot_in = {quot_ff[GW-2:0], 1'b0};
         end
      end
   end

   // input capture and result register
   always_comb begin
      x_in         = cmd.load_item ? CW'(req_pixel_x) : x_ff;
      y_in         = cmd.load_item ? CW'(req_pixel_y) : y_ff;
      rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);
      rsp_value_in = rsp_value_ff;
      rsp_mx_in    = rsp_mx_ff;
      rsp_my_in    = rsp_my_ff;
      if (cmd.emit) begin
         rsp_value_in = cmd.emit_quot ? quot_ff : pix_value;
         rsp_mx_in    = ramp_mode ? '0 : MXW'(mx_ff);
         rsp_my_in    = ramp_mode ? '0 : my_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= sfpg_pkg::RESET_MODE;
         width_ff     <= sfpg_pkg::RESET_WIDTH;
         height_ff    <= sfpg_pkg::RESET_HEIGHT;
         amp_ff       <= sfpg_pkg::RESET_AMPLITUDE;
         grey_ff      <= sfpg_pkg::RESET_MAX_GREY;
         phase_ff     <= '0;
         sd_ff        <= sfpg_pkg::SINGLE_DARK_RELOAD;
         sb_ff        <= sfpg_pkg::SINGLE_BRIGHT_RELOAD;
         ad_ff        <= sfpg_pkg::ALT_DARK_RELOAD;
         ab_ff        <= sfpg_pkg::ALT_BRIGHT_RELOAD;
         bright_ff    <= 1'b0;
         mx_ff        <= '0;
         my_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         amp_ff       <= amp_in;
         grey_ff      <= grey_in;
         phase_ff     <= phase_in;
         sd_ff        <= sd_in;
         sb_ff        <= sb_in;
         ad_ff        <= ad_in;
         ab_ff        <= ab_in;
         bright_ff    <= bright_in;
         mx_ff        <= mx_in;
         my_ff        <= my_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      sin_mag_ff   <= sin_mag_in;
      sin_neg_ff   <= sin_neg_in;
      amp50_ff     <= amp50_in;
      scale_ff     <= scale_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      rsp_value_ff <= rsp_value_in;
      rsp_mx_ff    <= rsp_mx_in;
      rsp_my_ff    <= rsp_my_in;
   end

   always_comb begin
      status.in_update   = req_frame_start && !ramp_mode;
      status.need_divide = ramp_mode && in_frame && !band;
      status.div_last    = (cnt_ff == CNTW'(GW - 1));
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_value_ff;
   assign rsp_marker_x    = rsp_mx_ff;
   assign rsp_marker_y    = rsp_my_ff;

   `SFPG_ASSERT_IMPLIES(a_phase_range, 1'b1, 32'(phase_ff) < PHASE_STEPS, "phase index out of range")
   `SFPG_ASSERT_IMPLIES(a_alt_counts, ad_ff == '0, ab_ff != '0, "both alternating countdowns empty")
   `SFPG_ASSERT_IMPLIES(a_ramp_quot, cmd.emit && cmd.emit_quot, quot_ff <= grey_ff, "ramp quotient above full grey")

endmodule

`default_nettype wire

FILE: rtl/synthetic_fluoro_pattern_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// req_*     in         req_valid/stall    pixel_x, pixel_y, frame_start
// rsp_*     out        rsp_valid/stall    pixel_value, marker_x, marker_y
// csr_*     in         csr_write_enable   csr_index, csr_write_data
//
// Sequencing: a clip, pulse or line pixel needs only the pixel state; once busy,
//   the engine takes the next request as it emits a result. A frame-start
//   transaction in modes 1 to 4 first passes the sine table read, amplitude
//   multiply and marker placement. A ramp pixel outside the bands adds
//   max_grey*x and the one-bit-a-cycle restoring divider by the frame width.
// Reset: synchronous, active high; configuration returns to its defaults and the
//   frame state goes back to phase zero, reloaded pulse countdowns, the dark
//   palette and a marker at the origin.
// Stalls: the result register holds a finished transaction under rsp_stall while
//   the next request is already captured; req_stall rises while work is pending.

module synthetic_fluoro_pattern_generator_core #(
   parameter int PHASE_STEPS    = sfpg_pkg::PHASE_STEPS_DEFAULT,
   parameter int COORD_BITS     = sfpg_pkg::COORD_BITS_DEFAULT,
   parameter int SINE_FRAC_BITS = sfpg_pkg::SINE_FRAC_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [sfpg_pkg::PIXEL_X_W-1:0]      req_pixel_x,
   input  wire logic [sfpg_pkg::PIXEL_Y_W-1:0]      req_pixel_y,
   input  wire logic                                req_frame_start,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [sfpg_pkg::GREY_W-1:0]              rsp_pixel_value,
   output logic [sfpg_pkg::MARKER_X_W-1:0]          rsp_marker_x,
   output logic signed [sfpg_pkg::MARKER_Y_W-1:0]   rsp_marker_y,
   input  wire logic                                csr_write_enable,
   input  wire logic [sfpg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sfpg_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // controller drives the datapath only through these
   sfpg_pkg::sfpg_cmd_type    ctrl_cmd;
   sfpg_pkg::sfpg_status_type dp_status;

   // sequencing: accept, frame update steps, divider iterations, result hand-off
   sfpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // configuration, frame state, pixel rules, divider and result register
   sfpg_datapath #(
      .PHASE_STEPS    (PHASE_STEPS),
      .COORD_BITS     (COORD_BITS),
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_frame_start  (req_frame_start),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_marker_x     (rsp_marker_x),
      .rsp_marker_y     (rsp_marker_y),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (ctrl_cmd),
      .status           (dp_status)
   );

endmodule

`default_nettype wire

FILE: test/tb_synthetic_fluoro_pattern_generator_core.sv
`timescale 1ns / 1ps

module tb_synthetic_fluoro_pattern_generator_core;
   import sfpg_pkg::*;

   localparam int STEPS          = PHASE_STEPS_DEFAULT;
   localparam int SINE_BITS      = SINE_FRAC_BITS_DEFAULT;
   localparam int FULL_SIZE      = 1 << COORD_BITS_DEFAULT;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int IDLE_PCT       = 31;
   localparam int PHASE_COUNT    = 24;
   localparam int PHASE_ITEMS    = 72;

   typedef struct packed {
      logic [PIXEL_X_W-1:0] x;
      logic [PIXEL_Y_W-1:0] y;
      logic                 frame_start;
   } pixel_req_t;

   typedef struct packed {
      logic [GREY_W-1:0]     pixel_value;
      logic [MARKER_X_W-1:0] marker_x;
      logic [MARKER_Y_W-1:0] marker_y;
   } pixel_rsp_t;

   // Drive every input to a known value from time zero.
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [PIXEL_X_W-1:0]          req_pixel_x = '0;
   logic [PIXEL_Y_W-1:0]          req_pixel_y = '0;
   logic                          req_frame_start = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [GREY_W-1:0]             rsp_pixel_value;
   logic [MARKER_X_W-1:0]         rsp_marker_x;
   logic signed [MARKER_Y_W-1:0]  rsp_marker_y;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_write_data = '0;

   // Register shadow, kept in step with every csr write.
   logic [MODE_W-1:0]  cfg_mode;
   logic [SIZE_W-1:0]  cfg_width;
   logic [SIZE_W-1:0]  cfg_height;
   logic [AMP_W-1:0]   cfg_amp;
   logic [GREY_W-1:0]  cfg_max_grey;

   // Frame state as the generator should hold it.
   longint             sine_lut [STEPS];
   int                 ph_index;
   logic [SD_W-1:0]    sd_count;
   logic [SB_W-1:0]    sb_count;
   logic [AD_W-1:0]    ad_count;
   logic [AB_W-1:0]    ab_count;
   logic               bright;
   int                 mk_x;
   int                 mk_y;

   // Lookahead copy of the marker, used only to aim stimulus at it.
   int                 gen_phase;
   int                 gen_mx;
   int                 gen_my;

   pixel_req_t         pending_q[$];
   pixel_rsp_t         pixel_expect_q[$];
   pixel_req_t         cur_pixel;
   logic               req_taken = 1'b0;
   int                 n_queued = 0;
   int                 n_accepted = 0;
   int                 n_checked = 0;
   int                 frames_begun = 0;
   int                 settings_used = 0;
   int                 fail_count = 0;
   int                 cycles = 0;
   bit                 steady_flow = 1'b0;
   bit                 rx_hold_req = 1'b0;
   bit                 rx_hold_ack = 1'b0;
   int                 rx_hold_left = 0;

   synthetic_fluoro_pattern_generator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_marker_x     (rsp_marker_x),
      .rsp_marker_y     (rsp_marker_y),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Sine of step k in signed Q15: fold into the first quadrant, sum the
   // Taylor series to x^15 in Q30 with every term truncated, round to Q15.
   function automatic longint sin_q15(int k);
      longint unsigned u, q, r, g, xa, x2, term, val;
      longint          sum;
      int              n;
      u = 4 * k;
      q = u / STEPS;
      r = u % STEPS;
      g = q[0] ? STEPS - r : r;
      xa = (HALF_PI_Q30 * g) / STEPS;
      x2 = (xa * xa) >> 30;
      term = xa;
      sum = longint'(xa);
      for (n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      val = (longint'(sum) + (64'd1 << (29 - SINE_BITS))) >> (30 - SINE_BITS);
      if (val > (64'd1 << SINE_BITS)) val = 64'd1 << SINE_BITS;
      return (q >= 2) ? -longint'(val) : longint'(val);
   endfunction

   // Clamp a size register to 1 .. 2^COORD_BITS.
   function automatic int eff_size(logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > FULL_SIZE) return FULL_SIZE;
      return int'(v);
   endfunction

   // Unused mode codes fall back to the moving clip.
   function automatic logic [MODE_W-1:0] eff_mode(logic [MODE_W-1:0] m);
      return (m > MODE_LINE) ? MODE_CLIP : m;
   endfunction

   // Marker centre row for a given phase step, saturated to 13 bits.
   function automatic int marker_row(int phase, int h);
      longint          s, off, row;
      longint unsigned mag;
      s = sine_lut[phase];
      mag = (s < 0) ? -s : s;
      off = longint'((longint'(MOTION_ROWS) * cfg_amp * mag) >> (AMP_FRAC_BITS + SINE_BITS));
      row = h / 2 + ((s < 0) ? -off : off);
      if (row > MARKER_Y_MAX) row = MARKER_Y_MAX;
      if (row < MARKER_Y_MIN) row = MARKER_Y_MIN;
      return int'(row);
   endfunction

   task automatic init_model();
      int k;
      for (k = 0; k < STEPS; k++) sine_lut[k] = sin_q15(k);
      cfg_mode = RESET_MODE;
      cfg_width = RESET_WIDTH;
      cfg_height = RESET_HEIGHT;
      cfg_amp = RESET_AMPLITUDE;
      cfg_max_grey = RESET_MAX_GREY;
      ph_index = 0;
      sd_count = SINGLE_DARK_RELOAD;
      sb_count = SINGLE_BRIGHT_RELOAD;
      ad_count = ALT_DARK_RELOAD;
      ab_count = ALT_BRIGHT_RELOAD;
      bright = 1'b0;
      mk_x = 0;
      mk_y = 0;
      gen_phase = 0;
      gen_mx = 0;
      gen_my = 0;
   endtask

   // Frame start in modes 1 to 4: place the marker, step the phase, and
   // run the pulse countdowns for the two pulse modes.
   task automatic advance_frame(logic [MODE_W-1:0] mode, int w, int h);
      mk_x = w / 2;
      mk_y = marker_row(ph_index, h);
      ph_index = (ph_index + 1) % STEPS;
      if (mode == MODE_SINGLE) begin
         // Dark for ten frames, bright for twenty, then dark for good.
         if (sd_count != 0 || sb_count == 0) begin
            if (sd_count != 0) sd_count = sd_count - 1'b1;
            bright = 1'b0;
         end else begin
            sb_count = sb_count - 1'b1;
            bright = 1'b1;
         end
      end else if (mode == MODE_ALT) begin
         if (ad_count != 0) begin
            ad_count = ad_count - 1'b1;
            if (ad_count == 0) ab_count = ALT_BRIGHT_RELOAD;
            bright = 1'b0;
         end else begin
            ab_count = ab_count - 1'b1;
            if (ab_count == 0) ad_count = ALT_DARK_RELOAD;
            bright = 1'b1;
         end
      end
   endtask

   // Work out the pixel result of one accepted transaction and queue it.
   task automatic predict_pixel(pixel_req_t item);
      logic [MODE_W-1:0] mode;
      logic [GREY_W-1:0] pix, bg, fg;
      int                w, h, xi, yi, dx, dy;
      pixel_rsp_t        r;
      mode = eff_mode(cfg_mode);
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      xi = int'(item.x);
      yi = int'(item.y);
      if (item.frame_start) frames_begun++;
      if (item.frame_start && mode != MODE_RAMP) advance_frame(mode, w, h);
      pix = '0;
      bg = CLIP_BG;
      fg = CLIP_FG;
      // Anything outside the frame stays black.
      if (xi < w && yi < h) begin
         if (mode == MODE_RAMP) begin
            if (yi < RAMP_BAND_ROWS || yi > h - RAMP_BAND_ROWS) pix = cfg_max_grey;
            else pix = GREY_W'((longint'(cfg_max_grey) * xi) / w);
         end else begin
            if (mode == MODE_SINGLE) begin
               bg = bright ? BRIGHT_BG : SINGLE_DARK_BG;
               fg = bright ? BRIGHT_FG : DARK_FG;
            end
            if (mode == MODE_ALT) begin
               bg = bright ? BRIGHT_BG : ALT_DARK_BG;
               fg = bright ? BRIGHT_FG : DARK_FG;
            end
            pix = bg;
            if (mode == MODE_LINE && (xi == yi || xi == yi + (w - h) ||
                                      xi == w - 1 - yi || xi == h - 1 - yi))
               pix = LINE_LEVEL;
            // The marker is drawn over the diagonals.
            dx = xi - mk_x;
            dy = yi - mk_y;
            if (dx >= -MARK_HALF_W && dx <= MARK_HALF_W &&
                dy >= -MARK_HALF_H && dy <= MARK_HALF_H)
               pix = fg;
         end
      end
      r.pixel_value = pix;
      r.marker_x = (mode == MODE_RAMP) ? '0 : MARKER_X_W'(mk_x);
      r.marker_y = (mode == MODE_RAMP) ? '0 : MARKER_Y_W'(mk_y);
      pixel_expect_q.push_back(r);
   endtask

   // Queue one pixel request; track where the marker will be for aiming.
   task automatic queue_item(int x, int y, bit fs);
      pixel_req_t        item;
      logic [MODE_W-1:0] mode;
      item.x = PIXEL_X_W'(x);
      item.y = PIXEL_Y_W'(y);
      item.frame_start = fs;
      mode = eff_mode(cfg_mode);
      if (fs && mode != MODE_RAMP) begin
         gen_mx = eff_size(cfg_width) / 2;
         gen_my = marker_row(gen_phase, eff_size(cfg_height));
         gen_phase = (gen_phase + 1) % STEPS;
      end
      pending_q.push_back(item);
      n_queued++;
   endtask

   // One well-formed frame: a frame start, then pixels aimed at the marker,
   // the diagonals and the ramp bands, with some plain and stray pixels.
   task automatic gen_frame(int npix);
      int w, h, xx, yy, k, sel;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      queue_item($urandom_range(w - 1), $urandom_range(h - 1), 1'b1);
      for (k = 1; k < npix; k++) begin
         sel = $urandom_range(19);
         if (sel < 7) begin
            xx = gen_mx + int'($urandom_range(8)) - 4;
            yy = gen_my + int'($urandom_range(12)) - 6;
         end else if (sel < 11) begin
            yy = $urandom_range(h - 1);
            case ($urandom_range(3))
               0: xx = yy;
               1: xx = yy + (w - h);
               2: xx = w - 1 - yy;
               default: xx = h - 1 - yy;
            endcase
         end else if (sel < 14) begin
            xx = $urandom_range(w - 1);
            case ($urandom_range(6))
               0: yy = 0;
               1: yy = RAMP_BAND_ROWS - 1;
               2: yy = RAMP_BAND_ROWS;
               3: yy = h - RAMP_BAND_ROWS - 1;
               4: yy = h - RAMP_BAND_ROWS;
               5: yy = h - RAMP_BAND_ROWS + 1;
               default: yy = h - 1;
            endcase
         end else if (sel < 18) begin
            xx = $urandom_range(w - 1);
            yy = $urandom_range(h - 1);
         end else begin
            xx = $urandom_range(FULL_SIZE - 1);
            yy = $urandom_range(FULL_SIZE - 1);
         end
         // A stray frame start now and then breaks the frame up.
         queue_item(xx, yy, $urandom_range(99) < 3);
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         REG_PATTERN_MODE: cfg_mode = data[MODE_W-1:0];
         REG_FRAME_WIDTH:  cfg_width = data[SIZE_W-1:0];
         REG_FRAME_HEIGHT: cfg_height = data[SIZE_W-1:0];
         REG_AMPLITUDE:    cfg_amp = data[AMP_W-1:0];
         REG_MAX_GREY:     cfg_max_grey = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Sizes lean small so the ramp bands and diagonals get hit often.
   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(9))
         0: return '0;
         1: return SIZE_W'(1);
         2: return SIZE_W'(FULL_SIZE);
         3: return '1;
         4: return SIZE_W'($urandom_range(8191, FULL_SIZE + 1));
         5: return SIZE_W'($urandom_range(FULL_SIZE - 1, 97));
         default: return SIZE_W'($urandom_range(96, 2));
      endcase
   endfunction

   function automatic logic [AMP_W-1:0] pick_amp();
      case ($urandom_range(4))
         0: return '0;
         1: return AMP_W'(2560);
         2: return '1;
         default: return AMP_W'($urandom_range(4095));
      endcase
   endfunction

   function automatic logic [GREY_W-1:0] pick_grey();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         default: return GREY_W'($urandom_range(65535));
      endcase
   endfunction

   // Random setting for one phase; unused upper data bits get noise too.
   task automatic pick_settings(logic [MODE_W-1:0] mode);
      write_reg(REG_PATTERN_MODE, {13'($urandom), mode});
      write_reg(REG_FRAME_WIDTH, {3'($urandom), pick_size()});
      write_reg(REG_FRAME_HEIGHT, {3'($urandom), pick_size()});
      write_reg(REG_AMPLITUDE, {4'($urandom), pick_amp()});
      write_reg(REG_MAX_GREY, pick_grey());
   endtask

   // Hold until every queued transaction is in and every result is back.
   task automatic settle();
      while (!(n_accepted == n_queued && pixel_expect_q.size() == 0)) @(posedge clock);
   endtask

   // Note each accepted transaction and predict its result.
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
         predict_pixel(cur_pixel);
         n_accepted++;
      end
   end

   // Request driver: hold the payload while stalled, otherwise advance to
   // the next pending pixel or idle at random.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_q.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
            cur_pixel = pending_q.pop_front();
            req_valid <= 1'b1;
            req_pixel_x <= cur_pixel.x;
            req_pixel_y <= cur_pixel.y;
            req_frame_start <= cur_pixel.frame_start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: stall at random, or hold off for a long stretch when
   // asked so the block backs up into its request side.
   always @(negedge clock) begin
      if (rx_hold_req != rx_hold_ack) begin
         rx_hold_ack = rx_hold_req;
         rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : result_check
      pixel_rsp_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_expect_q.size() == 0) begin
            $error("pixel result with no request outstanding: pixel_value %0d",
                   rsp_pixel_value);
            fail_count++;
         end else begin
            want = pixel_expect_q.pop_front();
            n_checked++;
            if (rsp_pixel_value !== want.pixel_value) begin
               $error("pixel_value: expected %0d, got %0d", want.pixel_value, rsp_pixel_value);
               fail_count++;
            end
            if (rsp_marker_x !== want.marker_x) begin
               $error("marker_x: expected %0d, got %0d", want.marker_x, rsp_marker_x);
               fail_count++;
            end
            if (rsp_marker_y !== want.marker_y) begin
               $error("marker_y: expected %0d, got %0d",
                      $signed(want.marker_y), rsp_marker_y);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: count cycles and end the run if it hangs.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Run timed out after %0d cycles with %0d results outstanding",
               cycles, pixel_expect_q.size());
      $display("** synthetic_fluoro_pattern_generator_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int                p, phase_base;
      logic [MODE_W-1:0] mode;
      init_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset setting, moving clip: first frame at phase zero puts the
      // marker at the frame centre. Hit its corners, just outside, the far
      // corner of the coordinate space and the origin.
      queue_item(1024, 768, 1'b1);
      queue_item(1021, 763, 1'b0);
      queue_item(1027, 773, 1'b0);
      queue_item(1028, 768, 1'b0);
      queue_item(4095, 4095, 1'b0);
      queue_item(0, 0, 1'b0);
      settle();

      // Ramp at full width and grey: both band edges, the one ramp row and
      // a row past the bottom. Frame start here must leave the phase alone.
      write_reg(REG_PATTERN_MODE, MODE_RAMP);
      write_reg(REG_FRAME_WIDTH, FULL_SIZE);
      write_reg(REG_FRAME_HEIGHT, 100);
      write_reg(REG_MAX_GREY, '1);
      queue_item(0, 0, 1'b1);
      queue_item(4095, 49, 1'b0);
      queue_item(4095, 50, 1'b0);
      queue_item(2048, 51, 1'b0);
      queue_item(4095, 99, 1'b0);
      queue_item(0, 100, 1'b0);
      settle();

      // Line mode in a 64x48 frame with amplitude 2560: one pixel on
      // each of the four diagonals, and the last pixel of the frame.
      write_reg(REG_PATTERN_MODE, MODE_LINE);
      write_reg(REG_FRAME_WIDTH, 64);
      write_reg(REG_FRAME_HEIGHT, 48);
      write_reg(REG_AMPLITUDE, 2560);
      write_reg(REG_MAX_GREY, '0);
      queue_item(32, 24, 1'b1);
      queue_item(5, 5, 1'b0);
      queue_item(21, 5, 1'b0);
      queue_item(58, 5, 1'b0);
      queue_item(42, 5, 1'b0);
      queue_item(63, 47, 1'b0);
      settle();

      // Unused mode code with zero sizes and the largest amplitude.
      write_reg(REG_PATTERN_MODE, 7);
      write_reg(REG_FRAME_WIDTH, 0);
      write_reg(REG_FRAME_HEIGHT, 0);
      write_reg(REG_AMPLITUDE, 4095);
      queue_item(0, 0, 1'b1);
      queue_item(1, 0, 1'b0);
      queue_item(0, 1, 1'b0);
      settle();

      // Oversized frame in both pulse modes.
      write_reg(REG_PATTERN_MODE, MODE_SINGLE);
      write_reg(REG_FRAME_WIDTH, 8191);
      write_reg(REG_FRAME_HEIGHT, 8191);
      queue_item(4095, 4095, 1'b1);
      queue_item(2048, 2048, 1'b0);
      settle();
      write_reg(REG_PATTERN_MODE, MODE_ALT);
      queue_item(0, 0, 1'b1);
      queue_item(4095, 4095, 1'b0);

      // Random phases: fresh setting each time, all eight mode codes in turn.
      // Pulse-mode frames are kept short so the countdowns run through.
      for (p = 0; p < PHASE_COUNT; p++) begin
         settle();
         mode = MODE_W'(p % 8);
         pick_settings(mode);
         settings_used++;
         steady_flow = (p == 6);
         if (p == 10) rx_hold_req = ~rx_hold_req;
         gen_phase = ph_index;
         gen_mx = mk_x;
         gen_my = mk_y;
         phase_base = n_queued;
         while (n_queued - phase_base < PHASE_ITEMS) begin
            if (mode == MODE_SINGLE || mode == MODE_ALT) gen_frame($urandom_range(6, 1));
            else gen_frame($urandom_range(14, 1));
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pixel_expect_q.size() != 0) begin
         $error("%0d expected pixel results never arrived", pixel_expect_q.size());
         fail_count++;
      end
      $display("Checked %0d pixel results over %0d frame starts, %0d random settings.",
               n_checked, frames_begun, settings_used);
      $display("Ran %0d cycles; %0d mismatches.", cycles, fail_count);
      if (fail_count == 0) begin
         $display("** synthetic_fluoro_pattern_generator_core: PASSED **");
      end else begin
         $display("** synthetic_fluoro_pattern_generator_core: FAILED **");
      end
      $finish;
   end

endmodule
